FILE: rtl/jsds_pkg.sv
// ----------------------------------------------------------------------------
// jsds_pkg
// Shared types and constants of the job sequencing scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package jsds_pkg;

    localparam int MAX_JOBS_DEF = 256;
    localparam int DL_W         = 16;
    localparam int PR_W         = 16;
    localparam int DONE_W       = 9;
    localparam int TOTAL_W      = 24;

    typedef struct packed {
        logic [DL_W-1:0] job_deadline;
        logic [PR_W-1:0] job_profit;
        logic            last_job;
    } t_job;

    typedef struct packed {
        logic [DONE_W-1:0]  jobs_done;
        logic [TOTAL_W-1:0] total_profit;
        logic               too_many;
    } t_res;

    typedef struct packed {
        logic load;
        logic clr;
        logic pick_init;
        logic pick;
        logic place_init;
        logic place;
        logic next;
        logic out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pick_done;
        logic place_done;
        logic k_last;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/jsds_datapath.sv
// ----------------------------------------------------------------------------
// jsds_datapath
// Job stores, slot map, scan counters and result accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module jsds_datapath #(
    parameter int MAX_JOBS = jsds_pkg::MAX_JOBS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  jsds_pkg::t_job    i_job,
    input  jsds_pkg::t_cmd    i_cmd,
    output jsds_pkg::t_sts    o_sts,
    output jsds_pkg::t_res    o_res
);

    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [jsds_pkg::DL_W-1:0] m_dl   [MAX_JOBS];
    logic [jsds_pkg::PR_W-1:0] m_pr   [MAX_JOBS];
    logic                      m_used [MAX_JOBS];
    logic                      m_free [MAX_JOBS];

    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [AW-1:0] r_caddr;
    logic [CW-1:0] r_k;

    logic [AW-1:0]             r_jaddr, r_jtag;
    logic                      r_jiss, r_jvld;
    logic [jsds_pkg::DL_W-1:0] r_rd_dl;
    logic [jsds_pkg::PR_W-1:0] r_rd_pr;
    logic                      r_rd_used;

    logic                      r_have;
    logic [AW-1:0]             r_best_idx;
    logic [jsds_pkg::DL_W-1:0] r_best_dl;
    logic [jsds_pkg::PR_W-1:0] r_best_pr;

    logic [AW-1:0] r_saddr, r_stag;
    logic          r_siss, r_svld, r_skip;
    logic          r_rd_free;

    logic [jsds_pkg::DONE_W-1:0]  r_done;
    logic [jsds_pkg::TOTAL_W-1:0] r_total;
    jsds_pkg::t_res               r_res;

    logic [CW-1:0]             w_nm1;
    logic [jsds_pkg::DL_W-1:0] w_n16;
    logic [jsds_pkg::DL_W-1:0] w_limit;
    logic                      w_hit;
    logic                      w_better;
    logic [jsds_pkg::TOTAL_W:0] w_sum;

    assign w_nm1    = r_cnt - CW'(1);
    assign w_n16    = jsds_pkg::DL_W'(r_cnt);
    assign w_limit  = (r_best_dl < w_n16) ? r_best_dl : w_n16;
    assign w_hit    = i_cmd.place && r_svld && r_rd_free;
    assign w_better = r_jvld && !r_rd_used && (!r_have || (r_rd_pr > r_best_pr));
    assign w_sum    = (jsds_pkg::TOTAL_W+1)'(r_total) + (jsds_pkg::TOTAL_W+1)'(r_best_pr);

    assign o_sts.clr_last   = (r_caddr == w_nm1[AW-1:0]);
    assign o_sts.pick_done  = r_jvld && (r_jtag == w_nm1[AW-1:0]);
    assign o_sts.place_done = r_skip || (r_svld && (r_rd_free || (r_stag == '0)));
    assign o_sts.k_last     = (r_k == w_nm1);
    assign o_res            = r_res;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < CW'(MAX_JOBS))) begin
            m_dl[r_cnt[AW-1:0]] <= i_job.job_deadline;
            m_pr[r_cnt[AW-1:0]] <= i_job.job_profit;
        end
        if (i_cmd.clr) begin
            m_used[r_caddr] <= 1'b0;
        end else if (i_cmd.place_init) begin
            m_used[r_best_idx] <= 1'b1;
        end
        if (i_cmd.clr) begin
            m_free[r_caddr] <= 1'b1;
        end else if (w_hit) begin
            m_free[r_stag] <= 1'b0;
        end
        r_rd_dl   <= m_dl[r_jaddr];
        r_rd_pr   <= m_pr[r_jaddr];
        r_rd_used <= m_used[r_jaddr];
        r_rd_free <= m_free[r_saddr];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_caddr <= '0;
            r_k     <= '0;
            r_jiss  <= 1'b0;
            r_jvld  <= 1'b0;
            r_siss  <= 1'b0;
            r_svld  <= 1'b0;
            r_skip  <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_JOBS)) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.clr) begin
                r_caddr <= r_caddr + AW'(1);
                r_k     <= '0;
            end
            if (i_cmd.pick_init) begin
                r_jaddr <= '0;
                r_jiss  <= 1'b1;
                r_jvld  <= 1'b0;
                r_have  <= 1'b0;
            end
            if (i_cmd.pick) begin
                r_jvld <= r_jiss;
                r_jtag <= r_jaddr;
                if (r_jiss) begin
                    if (r_jaddr == w_nm1[AW-1:0]) begin
                        r_jiss <= 1'b0;
                    end else begin
                        r_jaddr <= r_jaddr + AW'(1);
                    end
                end
                if (w_better) begin
                    r_have     <= 1'b1;
                    r_best_idx <= r_jtag;
                    r_best_dl  <= r_rd_dl;
                    r_best_pr  <= r_rd_pr;
                end
            end
            if (i_cmd.place_init) begin
                r_saddr <= AW'(w_limit - jsds_pkg::DL_W'(1));
                r_siss  <= (w_limit != '0);
                r_skip  <= (w_limit == '0);
                r_svld  <= 1'b0;
            end
            if (i_cmd.place) begin
                r_svld <= r_siss;
                r_stag <= r_saddr;
                if (r_siss) begin
                    if (r_saddr == '0) begin
                        r_siss <= 1'b0;
                    end else begin
                        r_saddr <= r_saddr - AW'(1);
                    end
                end
            end
            if (i_cmd.next) begin
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.out) begin
                r_cnt   <= '0;
                r_drop  <= 1'b0;
                r_caddr <= '0;
            end
        end
    end

    // accumulation and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_done  <= '0;
            r_total <= '0;
        end else if (w_hit) begin
            if (r_done != '1) begin
                r_done <= r_done + jsds_pkg::DONE_W'(1);
            end
            r_total <= w_sum[jsds_pkg::TOTAL_W] ? '1 : w_sum[jsds_pkg::TOTAL_W-1:0];
        end
        if (i_cmd.out) begin
            r_res.jobs_done    <= r_done;
            r_res.total_profit <= r_total;
            r_res.too_many     <= r_drop;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/jsds_ctrl.sv
// ----------------------------------------------------------------------------
// jsds_ctrl
// Phase sequencer: load, clear, pick, place, result.
// ----------------------------------------------------------------------------
`default_nettype none

module jsds_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_job_valid,
    input  wire            i_last,
    output logic           o_job_ready,
    output logic           o_res_valid,
    input  wire            i_res_ready,
    input  jsds_pkg::t_sts i_sts,
    output jsds_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD, S_CLEAR, S_PINIT, S_PICK, S_PLINIT, S_PLACE, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_res_valid;
    logic   w_out_ok;

    assign w_out_ok = !r_res_valid || i_res_ready;

    assign o_job_ready      = (r_state == S_LOAD);
    assign o_res_valid      = r_res_valid;
    assign o_cmd.load       = (r_state == S_LOAD) && i_job_valid;
    assign o_cmd.clr        = (r_state == S_CLEAR);
    assign o_cmd.pick_init  = (r_state == S_PINIT);
    assign o_cmd.pick       = (r_state == S_PICK);
    assign o_cmd.place_init = (r_state == S_PLINIT);
    assign o_cmd.place      = (r_state == S_PLACE);
    assign o_cmd.next       = (r_state == S_NEXT);
    assign o_cmd.out        = (r_state == S_OUT) && w_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_res_valid <= 1'b0;
        end else begin
            if (o_cmd.out) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (i_job_valid && i_last) begin
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_PINIT;
                    end
                end
                S_PINIT: r_state <= S_PICK;
                S_PICK: begin
                    if (i_sts.pick_done) begin
                        r_state <= S_PLINIT;
                    end
                end
                S_PLINIT: r_state <= S_PLACE;
                S_PLACE: begin
                    if (i_sts.place_done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= i_sts.k_last ? S_OUT : S_PINIT;
                end
                S_OUT: begin
                    if (w_out_ok) begin
                        r_state <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/job_sequencing_deadline_scheduler_unit.sv
// Loading: o_job_ready is high throughout the load phase, so a job beat is taken whenever
// i_job_valid is high; the beat marked last ends loading and starts scheduling.
// Scheduling: one job pick is a full scan of the job store and one slot search a walk of
// the slot map, each one memory read per cycle.
// Reset: synchronous active-low; clears the sequencer, job count and drop flag. The slot
// map and job flags are swept clear after each last beat.
// ----------------------------------------------------------------------------
// job_sequencing_deadline_scheduler_unit
// Batch job sequencing with deadlines, greedy by descending profit.
// ----------------------------------------------------------------------------
`default_nettype none

module job_sequencing_deadline_scheduler_unit #(
    parameter int MAX_JOBS = jsds_pkg::MAX_JOBS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_job_valid,
    output logic           o_job_ready,
    input  jsds_pkg::t_job i_job,
    output logic           o_res_valid,
    input  wire            i_res_ready,
    output jsds_pkg::t_res o_res
);

    jsds_pkg::t_cmd w_cmd;
    jsds_pkg::t_sts w_sts;

    jsds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (i_job_valid),
        .i_last      (i_job.last_job),
        .o_job_ready (o_job_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    jsds_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (i_job),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/jsds_checker.sv
// ----------------------------------------------------------------------------
// jsds_checker
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsds_checker #(
    parameter int MAX_JOBS = jsds_pkg::MAX_JOBS_DEF
) (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_job_valid,
    input wire            o_job_ready,
    input jsds_pkg::t_job i_job,
    input wire            o_res_valid,
    input wire            i_res_ready,
    input jsds_pkg::t_res o_res
);

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("stalled result beat changed");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_job_valid && o_job_ready && i_job.last_job) |=> !o_job_ready)
        else $error("ready after last beat");

    a_res_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> !$past(o_job_ready))
        else $error("result without scheduling phase");

    a_done_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (32'(o_res.jobs_done) <= MAX_JOBS))
        else $error("more jobs placed than capacity");

endmodule

bind job_sequencing_deadline_scheduler_unit jsds_checker #(.MAX_JOBS(MAX_JOBS)) u_jsds_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_job_valid (i_job_valid),
    .o_job_ready (o_job_ready),
    .i_job       (i_job),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

`default_nettype wire
